// ===== rtl/assert_macros.svh =====
// assertion macros shared by the interrupt source event counter rtl
// no dependencies; assertions compile away under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ISEC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ISEC_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ISEC_ASSERT(lbl, prop, msg)
`define ISEC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// ===== rtl/isec_pkg.sv =====
// package for the interrupt source event counter: codes, register indexes, shared types
// no dependencies
`timescale 1ns / 1ps
package isec_pkg;

   localparam int NUM_SOURCES_DEF   = 8;
   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int DATA_WIDTH        = 32;
   localparam int INDEX_WIDTH       = 5;

   typedef enum logic {
      CMD_EVENT  = 1'b0,
      CMD_ACCESS = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_ILLEGAL = 2'd0,
      DIR_WRITE   = 2'd1,
      DIR_READ    = 2'd2,
      DIR_SWAP    = 2'd3
   } dir_type;

   localparam logic [INDEX_WIDTH-1:0] IDX_ALIAS     = 5'd8;
   localparam logic [INDEX_WIDTH-1:0] IDX_COUNT_EN  = 5'd9;
   localparam logic [INDEX_WIDTH-1:0] IDX_NOTIFY_EN = 5'd10;
   localparam logic [INDEX_WIDTH-1:0] IDX_LAST_PEND = 5'd11;

   // decoded control from the merge stage to the lanes and the mask registers
   typedef struct packed {
      logic                   event_fire;
      logic                   write;
      logic                   cnt_access;
      logic [INDEX_WIDTH-1:0] cnt_sel;
      logic                   cen_access;
      logic                   nen_access;
      logic                   lpd_access;
   } ctl_type;

   typedef struct packed {
      logic                  notify;
      logic                  handled;
      logic                  access_error;
      logic [DATA_WIDTH-1:0] read_data;
   } rsp_type;

endpackage

// ===== rtl/isec_lane.sv =====
// one counter lane: wrapping event counter with its own write and read select
// depends on isec_pkg
`timescale 1ns / 1ps
module isec_lane #(
   parameter int COUNTER_WIDTH = isec_pkg::COUNTER_WIDTH_DEF,
   parameter int LANE_ID       = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  isec_pkg::ctl_type               ctl,
   input  logic                            hit,
   input  logic [isec_pkg::DATA_WIDTH-1:0] write_data,
   output logic [isec_pkg::DATA_WIDTH-1:0] rd_data
);

   logic [COUNTER_WIDTH-1:0] cnt_ff;
   logic [COUNTER_WIDTH-1:0] cnt_in;
   logic                     sel;
   logic [63:0]              wr_wide;
   logic [63:0]              cnt_wide;

   assign sel      = ctl.cnt_access && (ctl.cnt_sel == isec_pkg::INDEX_WIDTH'(LANE_ID));
   assign wr_wide  = {32'd0, write_data};
   assign cnt_wide = 64'(cnt_ff);
   assign rd_data  = sel ? cnt_wide[isec_pkg::DATA_WIDTH-1:0] : '0;

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl.write && sel) begin
         cnt_in = wr_wide[COUNTER_WIDTH-1:0];
      end else if (ctl.event_fire && hit) begin
         cnt_in = cnt_ff + COUNTER_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/isec_regs.sv =====
// count mask, notify mask and last pending word with their access path
// depends on isec_pkg
`timescale 1ns / 1ps
module isec_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  isec_pkg::ctl_type               ctl,
   input  logic [isec_pkg::DATA_WIDTH-1:0] pending_bits,
   input  logic [isec_pkg::DATA_WIDTH-1:0] write_data,
   output logic [isec_pkg::DATA_WIDTH-1:0] count_en,
   output logic [isec_pkg::DATA_WIDTH-1:0] notify_en,
   output logic [isec_pkg::DATA_WIDTH-1:0] rd_data
);

   logic [isec_pkg::DATA_WIDTH-1:0] cen_ff, cen_in;
   logic [isec_pkg::DATA_WIDTH-1:0] nen_ff, nen_in;
   logic [isec_pkg::DATA_WIDTH-1:0] lpd_ff, lpd_in;

   assign count_en  = cen_ff;
   assign notify_en = nen_ff;
   assign rd_data   = ({isec_pkg::DATA_WIDTH{ctl.cen_access}} & cen_ff)
                    | ({isec_pkg::DATA_WIDTH{ctl.nen_access}} & nen_ff)
                    | ({isec_pkg::DATA_WIDTH{ctl.lpd_access}} & lpd_ff);

   always_comb begin
      cen_in = cen_ff;
      nen_in = nen_ff;
      lpd_in = lpd_ff;
      if (ctl.write && ctl.cen_access) begin
         cen_in = write_data;
      end
      if (ctl.write && ctl.nen_access) begin
         nen_in = write_data;
      end
      if (ctl.write && ctl.lpd_access) begin
         lpd_in = write_data;
      end else if (ctl.event_fire) begin
         lpd_in = pending_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff <= '0;
         nen_ff <= '0;
         lpd_ff <= '0;
      end else begin
         cen_ff <= cen_in;
         nen_ff <= nen_in;
         lpd_ff <= lpd_in;
      end
   end

endmodule

// ===== rtl/isec_merge.sv =====
// item decode and merging of lane and register reads into one result
// depends on isec_pkg
`timescale 1ns / 1ps
module isec_merge #(
   parameter int NUM_SOURCES = isec_pkg::NUM_SOURCES_DEF
) (
   input  logic                             accept,
   input  isec_pkg::cmd_type                cmd,
   input  logic [isec_pkg::DATA_WIDTH-1:0]  pending_bits,
   input  logic [isec_pkg::INDEX_WIDTH-1:0] reg_index,
   input  isec_pkg::dir_type                direction,
   input  logic [isec_pkg::DATA_WIDTH-1:0]  lane_rd [NUM_SOURCES],
   input  logic [isec_pkg::DATA_WIDTH-1:0]  regs_rd,
   input  logic [isec_pkg::DATA_WIDTH-1:0]  notify_en,
   output isec_pkg::ctl_type                ctl,
   output isec_pkg::rsp_type                result
);

   localparam logic [isec_pkg::DATA_WIDTH-1:0] SRC_MASK =
      isec_pkg::DATA_WIDTH'((64'd1 << NUM_SOURCES) - 64'd1);

   logic                            is_acc;
   logic                            cnt_range;
   logic                            bad;
   logic                            legal;
   logic                            handled;
   logic [isec_pkg::DATA_WIDTH-1:0] rd_any;

   assign is_acc    = (cmd == isec_pkg::CMD_ACCESS);
   assign cnt_range = (reg_index <= isec_pkg::IDX_ALIAS);
   assign bad       = (direction == isec_pkg::DIR_ILLEGAL)
                    || (reg_index > isec_pkg::IDX_LAST_PEND)
                    || (cnt_range && (6'({2'b00, reg_index[2:0]}) >= 6'(NUM_SOURCES)));
   assign legal     = is_acc && !bad;
   assign handled   = !is_acc && ((pending_bits & SRC_MASK) != '0);

   always_comb begin
      ctl.event_fire = accept && handled;
      ctl.write      = accept && ((direction == isec_pkg::DIR_WRITE)
                                  || (direction == isec_pkg::DIR_SWAP));
      ctl.cnt_access = legal && cnt_range;
      ctl.cnt_sel    = {2'b00, reg_index[2:0]};
      ctl.cen_access = legal && (reg_index == isec_pkg::IDX_COUNT_EN);
      ctl.nen_access = legal && (reg_index == isec_pkg::IDX_NOTIFY_EN);
      ctl.lpd_access = legal && (reg_index == isec_pkg::IDX_LAST_PEND);
   end

   always_comb begin
      rd_any = regs_rd;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         rd_any = rd_any | lane_rd[i];
      end
   end

   always_comb begin
      result.read_data    = (legal && (direction != isec_pkg::DIR_WRITE)) ? rd_any : '0;
      result.access_error = is_acc && bad;
      result.handled      = handled;
      result.notify       = handled && ((pending_bits & notify_en) != '0);
   end

endmodule

// ===== rtl/interrupt_source_event_counter_unit.sv =====
// interrupt source event counter, top level: lanes, mask registers, merge, output skid
// depends on isec_pkg, isec_lane, isec_regs, isec_merge and assert_macros.svh
//
// usage:
//   req channel carries one item per handshake: an interrupt event (tuser = 0) with the
//   pending word, or a register access (tuser = 1) that writes, reads or swaps one of
//   the counters, the count mask, the notify mask or the last pending word.
//   rsp channel returns exactly one result item per request item, in order.
// throughput:
//   state is updated at the edge that accepts the item; its result is registered in the
//   output register or the skid register. one item per cycle is sustained while rsp
//   is ready; the next item sees all state changes of the one before it.
// reset:
//   synchronous, active high; clears all counters, both masks and the last pending
//   word, and empties the output stage.
// stalls:
//   a two-entry output stage (output register plus skid register) lets one more item
//   be accepted while a result waits; req_tready drops only when both are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module interrupt_source_event_counter_unit #(
   parameter int NUM_SOURCES   = isec_pkg::NUM_SOURCES_DEF,
   parameter int COUNTER_WIDTH = isec_pkg::COUNTER_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pending_bits[31:0], reg_index[36:32], direction[38:37], write_data[70:39], zero pad
   input  logic [71:0] req_tdata,
   // cmd[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[31:0], access_error[32], handled[33], notify[34], zero pad
   output logic [39:0] rsp_tdata
);

   logic                             accept;
   isec_pkg::cmd_type                cmd;
   logic [isec_pkg::DATA_WIDTH-1:0]  pending_bits;
   logic [isec_pkg::INDEX_WIDTH-1:0] reg_index;
   isec_pkg::dir_type                direction;
   logic [isec_pkg::DATA_WIDTH-1:0]  write_data;

   isec_pkg::ctl_type                ctl;
   isec_pkg::rsp_type                result;
   logic [isec_pkg::DATA_WIDTH-1:0]  lane_rd [NUM_SOURCES];
   logic [isec_pkg::DATA_WIDTH-1:0]  regs_rd;
   logic [isec_pkg::DATA_WIDTH-1:0]  count_en;
   logic [isec_pkg::DATA_WIDTH-1:0]  notify_en;

   isec_pkg::rsp_type out_ff, out_in;
   isec_pkg::rsp_type skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;

   assign cmd          = isec_pkg::cmd_type'(req_tuser[0]);
   assign pending_bits = req_tdata[31:0];
   assign reg_index    = req_tdata[36:32];
   assign direction    = isec_pkg::dir_type'(req_tdata[38:37]);
   assign write_data   = req_tdata[70:39];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   isec_merge #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_merge (
      .accept       (accept),
      .cmd          (cmd),
      .pending_bits (pending_bits),
      .reg_index    (reg_index),
      .direction    (direction),
      .lane_rd      (lane_rd),
      .regs_rd      (regs_rd),
      .notify_en    (notify_en),
      .ctl          (ctl),
      .result       (result)
   );

   isec_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .pending_bits (pending_bits),
      .write_data   (write_data),
      .count_en     (count_en),
      .notify_en    (notify_en),
      .rd_data      (regs_rd)
   );

   for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_lane
      isec_lane #(
         .COUNTER_WIDTH (COUNTER_WIDTH),
         .LANE_ID       (g)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .hit        (pending_bits[g] & count_en[g]),
         .write_data (write_data),
         .rd_data    (lane_rd[g])
      );
   end

   // output register with skid entry
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || rsp_tready) begin
         out_in        = skid_valid_ff ? skid_ff : result;
         out_valid_in  = skid_valid_ff || accept;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_ff.notify, out_ff.handled, out_ff.access_error,
                        out_ff.read_data};

   `ISEC_ASSERT(a_skid_needs_out, skid_valid_ff |-> out_valid_ff, "skid full with output empty")
   `ISEC_ASSERT(a_notify_handled, rsp_tvalid && rsp_tdata[34] |-> rsp_tdata[33],
                "notify without handled event")
   `ISEC_ASSERT(a_error_clean, rsp_tvalid && rsp_tdata[32] |-> (rsp_tdata[31:0] == '0)
                && !rsp_tdata[33], "refused access carries data")
   `ISEC_ASSERT_NR(a_reset_empty, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

// ===== test/isec_response_checker.sv =====
// response checker for the interrupt source event counter: watches req and rsp items,
// keeps its own copy of counters and masks, compares every result field by field
// depends on isec_pkg
`timescale 1ns / 1ps
module isec_response_checker
   import isec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // pending_bits[31:0], reg_index[36:32], direction[38:37], write_data[70:39], zero pad
   input  logic [71:0] req_tdata,
   // cmd[0]
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[31:0], access_error[32], handled[33], notify[34], zero pad
   input  logic [39:0] rsp_tdata,
   output int unsigned mismatch_count,
   output int unsigned results_owed
);

   localparam int NUM_SOURCES = NUM_SOURCES_DEF;
   localparam logic [31:0] SOURCE_MASK = 32'((64'd1 << NUM_SOURCES) - 1);

   logic [31:0] source_counts [NUM_SOURCES];
   logic [31:0] count_mask;
   logic [31:0] notify_mask;
   logic [31:0] last_pending_word;
   rsp_type     expected_results [$];
   int unsigned mismatches;

   function automatic rsp_type serve_item(input cmd_type cmd, input logic [31:0] pend,
                                          input logic [4:0] idx, input dir_type dir,
                                          input logic [31:0] data);
      rsp_type     r;
      logic [31:0] old_value;
      int          s;
      int          lane;
      r = '0;
      if (cmd == CMD_EVENT) begin
         if ((pend & SOURCE_MASK) != 0) begin
            r.handled = 1'b1;
            for (s = 0; s < NUM_SOURCES; s++) begin
               if (pend[s] && count_mask[s]) source_counts[s] = source_counts[s] + 1;
            end
            last_pending_word = pend;
            r.notify = |(pend & notify_mask);
         end
      end else if (dir == DIR_ILLEGAL || idx > IDX_LAST_PEND) begin
         r.access_error = 1'b1;
      end else begin
         lane = (idx == IDX_ALIAS) ? 0 : int'(idx);
         if (idx <= IDX_ALIAS && lane >= NUM_SOURCES) begin
            r.access_error = 1'b1;
         end else begin
            case (idx)
               IDX_COUNT_EN:  old_value = count_mask;
               IDX_NOTIFY_EN: old_value = notify_mask;
               IDX_LAST_PEND: old_value = last_pending_word;
               default:       old_value = source_counts[lane];
            endcase
            if (dir == DIR_READ) begin
               r.read_data = old_value;
            end else begin
               if (dir == DIR_SWAP) r.read_data = old_value;
               case (idx)
                  IDX_COUNT_EN:  count_mask = data;
                  IDX_NOTIFY_EN: notify_mask = data;
                  IDX_LAST_PEND: last_pending_word = data;
                  default:       source_counts[lane] = data;
               endcase
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (source_counts[i]) source_counts[i] = '0;
         count_mask = '0;
         notify_mask = '0;
         last_pending_word = '0;
         expected_results.delete();
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result item with no expectation waiting: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.read_data) begin
                  $error("read_data mismatch: expected %h, actual %h",
                         want.read_data, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[32] !== want.access_error) begin
                  $error("access_error mismatch: expected %b, actual %b",
                         want.access_error, rsp_tdata[32]);
                  mismatches++;
               end
               if (rsp_tdata[33] !== want.handled) begin
                  $error("handled mismatch: expected %b, actual %b",
                         want.handled, rsp_tdata[33]);
                  mismatches++;
               end
               if (rsp_tdata[34] !== want.notify) begin
                  $error("notify mismatch: expected %b, actual %b",
                         want.notify, rsp_tdata[34]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(serve_item(cmd_type'(req_tuser[0]), req_tdata[31:0],
                                                  req_tdata[36:32],
                                                  dir_type'(req_tdata[38:37]),
                                                  req_tdata[70:39]));
         end
      end
      mismatch_count <= mismatches;
      results_owed <= expected_results.size();
   end

endmodule

// ===== test/interrupt_source_event_counter_unit_tb.sv =====
// testbench top for the interrupt source event counter: clock, reset, directed and random
// items with random idling on both channels, verdict at the end
// depends on isec_pkg, isec_response_checker and the rtl of interrupt_source_event_counter_unit
`timescale 1ns / 1ps
module interrupt_source_event_counter_unit_tb;
   import isec_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT  = 500000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned cycle_count = 0;
   bit          idling_on = 1'b1;
   int          stall_left = 0;

   interrupt_source_event_counter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   isec_response_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side stalls at random, in bursts of random length
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (idling_on && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 18);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input cmd_type cmd, input logic [31:0] pend,
                            input logic [4:0] idx, input dir_type dir,
                            input logic [31:0] data);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {1'b0, data, dir, idx, pend};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_event(input logic [31:0] pend);
      send_item(CMD_EVENT, pend, 5'($urandom()), dir_type'($urandom_range(0, 3)), $urandom());
   endtask

   task automatic send_access(input logic [4:0] idx, input dir_type dir,
                              input logic [31:0] data);
      send_item(CMD_ACCESS, $urandom(), idx, dir, data);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'hffff_ffff - $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_pending();
      case ($urandom_range(0, 7))
         0:       return $urandom() & 32'hffff_ff00;
         1:       return 32'd1 << $urandom_range(0, 7);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      int n;
      int pick;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_access(IDX_COUNT_EN, DIR_READ, 32'h0);
      send_access(IDX_COUNT_EN, DIR_WRITE, 32'hffff_ffff);
      send_access(IDX_NOTIFY_EN, DIR_SWAP, 32'h0000_0100);
      send_event(32'h0000_0000);
      // unhandled even though bit 8 hits the notify mask
      send_event(32'hffff_ff00);
      send_access(IDX_LAST_PEND, DIR_READ, 32'h0);
      send_event(32'hffff_ffff);
      send_event(32'h0000_0001);
      send_access(5'd7, DIR_WRITE, 32'hffff_ffff);
      // counter wraps
      send_event(32'h0000_0080);
      send_access(5'd7, DIR_READ, 32'h0);
      send_access(IDX_ALIAS, DIR_SWAP, 32'h1234_5678);
      send_access(5'd0, DIR_READ, 32'h0);
      send_access(IDX_ALIAS, DIR_READ, 32'h0);
      send_access(IDX_LAST_PEND, DIR_SWAP, 32'ha5a5_a5a5);
      send_access(IDX_LAST_PEND, DIR_READ, 32'h0);
      send_access(5'd3, DIR_ILLEGAL, 32'hffff_ffff);
      send_access(5'd12, DIR_READ, 32'h0);
      send_access(5'd31, DIR_SWAP, 32'hffff_ffff);
      send_access(IDX_COUNT_EN, DIR_WRITE, 32'h0);
      send_event(32'hffff_ffff);
      send_access(IDX_NOTIFY_EN, DIR_WRITE, 32'h0);
      send_event(32'h8000_0001);
      send_access(5'd0, DIR_READ, 32'h0);
      send_access(IDX_COUNT_EN, DIR_WRITE, 32'h0000_00ff);

      // random part, idling switched per segment and off at the tail
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) idling_on = (n < RANDOM_ITEMS - 300) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_event(pick_pending());
         end else if (pick < 90) begin
            send_access(5'($urandom_range(0, 11)), dir_type'($urandom_range(1, 3)), pick_word());
         end else begin
            send_access(5'($urandom_range(0, 31)), dir_type'($urandom_range(0, 3)), $urandom());
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/isec_pkg.sv
rtl/isec_lane.sv
rtl/isec_regs.sv
rtl/isec_merge.sv
rtl/interrupt_source_event_counter_unit.sv
test/isec_response_checker.sv
test/interrupt_source_event_counter_unit_tb.sv
